@@ sv/spfq_pkg.sv @@
// Package for the strict-priority frame queues: sizes, result kinds, states.
package spfq_pkg;

  localparam int KeepaliveSlots = 2;
  localparam int EventSlots     = 8;
  localparam int DataSlots      = 4;
  localparam int MaxFrameBytes  = 64;
  localparam int NumClasses     = 3;
  localparam int TotalSlots     = KeepaliveSlots + EventSlots + DataSlots;
  localparam int SlotW          = $clog2(TotalSlots);
  localparam int ByteW          = $clog2(MaxFrameBytes);
  localparam int AddrW          = SlotW + ByteW;
  localparam int CountW         = $clog2(MaxFrameBytes + 2);
  localparam int QCountW        = 5;

  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_DROPPED  = 3'd1;
  localparam logic [2:0] KIND_BYTE     = 3'd2;
  localparam logic [2:0] KIND_NOTHING  = 3'd3;
  localparam logic [2:0] KIND_EMPTY    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_STREAM
  } state_t;

  // Number of slots for a class.
  function automatic logic [QCountW-1:0] class_slots(input logic [1:0] c);
    logic [QCountW-1:0] r;
    unique case (c)
      2'd0:    r = QCountW'(KeepaliveSlots);
      2'd1:    r = QCountW'(EventSlots);
      default: r = QCountW'(DataSlots);
    endcase
    return r;
  endfunction

  // First slot of a class in the shared store.
  function automatic logic [SlotW-1:0] class_base(input logic [1:0] c);
    logic [SlotW-1:0] r;
    unique case (c)
      2'd0:    r = '0;
      2'd1:    r = SlotW'(KeepaliveSlots);
      default: r = SlotW'(KeepaliveSlots + EventSlots);
    endcase
    return r;
  endfunction

endpackage

@@ sv/strict_priority_frame_queues_unit.sv @@
// Strict-priority frame queues: three FIFO queues of whole frames in one byte memory.
// Enqueue results are registered; a drain reads the length, then streams the bytes.
// Throughput, unless stalled: enqueue one byte per cycle; a drain blocks new input
// until done and streams one byte a cycle via the frame memory's single read port.
// Reset clears queue heads, counts and staging; the frame and length memories are
// left undefined and are only read at entries written before.
module strict_priority_frame_queues_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,   // last_byte
  input  logic [2:0]  s_tuser,   // action[0], queue_class[2:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_byte[7:0], copied_count[14:8], zero[15]
  output logic        m_tlast,   // last
  output logic [4:0]  m_tuser,   // kind[2:0], served_class[4:3]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int SlotW  = spfq_pkg::SlotW;
  localparam int ByteW  = spfq_pkg::ByteW;
  localparam int AddrW  = spfq_pkg::AddrW;
  localparam int CountW = spfq_pkg::CountW;
  localparam int QW     = spfq_pkg::QCountW;

  // memories
  logic [7:0] frame_mem [spfq_pkg::TotalSlots * spfq_pkg::MaxFrameBytes];
  logic [CountW-1:0] len_mem [spfq_pkg::TotalSlots];

  logic [6:0]  max_out_len;
  logic [QW-1:0] queue_head [spfq_pkg::NumClasses];
  logic [QW-1:0] queue_count [spfq_pkg::NumClasses];
  logic [CountW-1:0] staging_count;
  logic [1:0]  staging_class;
  logic        staging_bad;

  spfq_pkg::state_t state, state_next;
  logic [1:0]  dr_class;
  logic [SlotW-1:0] dr_slot;
  logic [6:0]  dr_n;
  logic [6:0]  dr_idx;
  logic [7:0]  rd_byte;
  logic [CountW-1:0] rd_len;

  // output register
  logic        o_valid;
  logic [2:0]  o_kind;
  logic [7:0]  o_byte;
  logic        o_last;
  logic [1:0]  o_class;
  logic [6:0]  o_count;
  logic        o_byte_sel;   // take out_byte from memory read data

  logic o_free;
  assign o_free = !o_valid || m_tready;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == spfq_pkg::ST_IDLE) && o_free;

  logic in_fire, is_drain;
  assign in_fire  = s_tvalid && s_tready;
  assign is_drain = s_tuser[0];

  // enqueue decode
  logic [1:0] eq_class;
  logic       eq_badc, eq_full, eq_store;
  logic [SlotW-1:0] eq_tail;
  logic [QW:0] tail_sum;
  assign eq_class = (staging_count == '0) ? s_tuser[2:1] : staging_class;
  assign eq_badc  = (eq_class == 2'd3);
  assign eq_full  = eq_badc ? 1'b1 :
                    (queue_count[eq_class] >= spfq_pkg::class_slots(eq_class));
  assign tail_sum = {1'b0, queue_head[eq_class]} + {1'b0, queue_count[eq_class]};
  always_comb begin
    logic [QW:0] t;
    t = tail_sum;
    if (t >= {1'b0, spfq_pkg::class_slots(eq_class)})
      t = t - {1'b0, spfq_pkg::class_slots(eq_class)};
    eq_tail = spfq_pkg::class_base(eq_class) + SlotW'(t);
  end
  assign eq_store = !eq_badc && !eq_full &&
                    (staging_count < CountW'(spfq_pkg::MaxFrameBytes));

  logic [CountW-1:0] cnt_inc;
  assign cnt_inc = (staging_count <= CountW'(spfq_pkg::MaxFrameBytes)) ?
                   staging_count + 1'b1 : staging_count;
  logic eq_accept;
  assign eq_accept = !staging_bad && eq_store;

  // drain selection
  logic [1:0] sel_class;
  logic       sel_none;
  always_comb begin
    sel_none  = 1'b0;
    sel_class = 2'd0;
    if (queue_count[0] != '0)      sel_class = 2'd0;
    else if (queue_count[1] != '0) sel_class = 2'd1;
    else if (queue_count[2] != '0) sel_class = 2'd2;
    else sel_none = 1'b1;
  end

  logic [6:0] len_clip, n_calc;
  assign len_clip = (rd_len > CountW'(spfq_pkg::MaxFrameBytes)) ?
                    7'(spfq_pkg::MaxFrameBytes) : 7'(rd_len);
  assign n_calc = (len_clip < max_out_len) ? len_clip : max_out_len;

  // load a result beat into the output register
  logic o_load;
  assign o_load = (in_fire && (is_drain ? sel_none : s_tlast)) ||
                  ((state == spfq_pkg::ST_LEN) && (n_calc == 7'd0) && o_free) ||
                  ((state == spfq_pkg::ST_STREAM) && o_free);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      spfq_pkg::ST_IDLE:
        if (in_fire && is_drain && !sel_none) state_next = spfq_pkg::ST_LEN;
      spfq_pkg::ST_LEN:
        if (n_calc != 7'd0) state_next = spfq_pkg::ST_STREAM;
        else if (o_free) state_next = spfq_pkg::ST_IDLE;
      spfq_pkg::ST_STREAM:
        if (o_free && (dr_idx == dr_n)) state_next = spfq_pkg::ST_IDLE;
      default: state_next = spfq_pkg::ST_IDLE;
    endcase
  end

  // memory read address: slot then byte index
  logic [AddrW-1:0] rd_addr;
  logic             rd_en;
  assign rd_addr = {dr_slot, ByteW'(dr_idx)};
  assign rd_en   = (state == spfq_pkg::ST_LEN) ||
                   ((state == spfq_pkg::ST_STREAM) && o_free && (dr_idx != dr_n));

  // frame memory
  always_ff @(posedge clk) begin
    if (in_fire && !is_drain && eq_store)
      frame_mem[{eq_tail, ByteW'(staging_count)}] <= s_tdata[7:0];
    if (rd_en) rd_byte <= frame_mem[rd_addr];
  end

  // length memory
  always_ff @(posedge clk) begin
    if (in_fire && !is_drain && s_tlast && eq_accept) len_mem[eq_tail] <= cnt_inc;
    if (in_fire && is_drain)
      rd_len <= len_mem[spfq_pkg::class_base(sel_class) + SlotW'(queue_head[sel_class])];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spfq_pkg::ST_IDLE;
      max_out_len   <= 7'd64;
      staging_count <= '0;
      staging_class <= '0;
      staging_bad   <= 1'b0;
      o_valid       <= 1'b0;
      o_byte_sel    <= 1'b0;
      dr_idx        <= '0;
      for (int i = 0; i < spfq_pkg::NumClasses; i++) begin
        queue_head[i]  <= '0;
        queue_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) max_out_len <= cfg_data;
      // load a new beat or drop the one taken
      if (o_load) o_valid <= 1'b1;
      else if (m_tready) o_valid <= 1'b0;

      if (in_fire && !is_drain) begin
        staging_class <= eq_class;
        if (s_tlast) begin
          staging_count <= '0;
          staging_bad   <= 1'b0;
          if (eq_accept) queue_count[eq_class] <= queue_count[eq_class] + 1'b1;
          o_byte_sel <= 1'b0;
          o_kind     <= eq_accept ? spfq_pkg::KIND_ACCEPTED : spfq_pkg::KIND_DROPPED;
          o_byte     <= '0;
          o_last     <= 1'b1;
          o_class    <= eq_badc ? 2'd0 : eq_class;
          o_count    <= '0;
        end else begin
          staging_count <= cnt_inc;
          staging_bad   <= staging_bad || !eq_store;
        end
      end

      if (in_fire && is_drain) begin
        if (sel_none) begin
          o_byte_sel <= 1'b0;
          o_kind     <= spfq_pkg::KIND_NOTHING;
          o_byte     <= '0;
          o_last     <= 1'b1;
          o_class    <= '0;
          o_count    <= '0;
        end else begin
          dr_class <= sel_class;
          dr_slot  <= spfq_pkg::class_base(sel_class) + SlotW'(queue_head[sel_class]);
          queue_head[sel_class] <=
            (queue_head[sel_class] + 1'b1 == spfq_pkg::class_slots(sel_class)) ?
            '0 : queue_head[sel_class] + 1'b1;
          queue_count[sel_class] <= queue_count[sel_class] - 1'b1;
          dr_idx <= '0;
        end
      end

      if (state == spfq_pkg::ST_LEN) begin
        dr_n   <= n_calc;
        dr_idx <= 7'd1;
        if (n_calc == 7'd0) begin
          if (o_free) begin
            o_byte_sel <= 1'b0;
            o_kind     <= spfq_pkg::KIND_EMPTY;
            o_byte     <= '0;
            o_last     <= 1'b1;
            o_class    <= dr_class;
            o_count    <= '0;
          end
        end
      end

      // stream: rd_byte holds byte dr_idx-1
      if (state == spfq_pkg::ST_STREAM && o_free) begin
        o_byte_sel <= 1'b1;
        o_kind     <= spfq_pkg::KIND_BYTE;
        o_last     <= (dr_idx == dr_n);
        o_class    <= dr_class;
        o_count    <= dr_n;
        if (dr_idx != dr_n) dr_idx <= dr_idx + 1'b1;
      end
    end
  end

  // hold streamed byte in output register
  logic [7:0] o_byte_q;
  always_ff @(posedge clk) begin
    if (state == spfq_pkg::ST_STREAM && o_free) o_byte_q <= rd_byte;
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {1'b0, o_count, (o_byte_sel ? o_byte_q : o_byte)};
  assign m_tlast  = o_last;
  assign m_tuser  = {o_class, o_kind};

`ifndef ASSERT_OFF
  a_cnt0: assert property (@(posedge clk) disable iff (rst)
    queue_count[0] <= QW'(spfq_pkg::KeepaliveSlots)) else $error("class 0 overfull");
  a_cnt1: assert property (@(posedge clk) disable iff (rst)
    queue_count[1] <= QW'(spfq_pkg::EventSlots)) else $error("class 1 overfull");
  a_cnt2: assert property (@(posedge clk) disable iff (rst)
    queue_count[2] <= QW'(spfq_pkg::DataSlots)) else $error("class 2 overfull");
  a_noin: assert property (@(posedge clk) disable iff (rst)
    (state != spfq_pkg::ST_IDLE) |-> !s_tready) else $error("input taken mid drain");
  a_byte: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_kind == spfq_pkg::KIND_BYTE) |-> (o_count != 7'd0))
    else $error("byte with zero count");
`endif

endmodule

@@ tb/spfq_checker.sv @@
// Checker for the strict-priority frame queues: predicts results from observed beats and compares.
module spfq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,   // last_byte
  input  logic [2:0]  s_tuser,   // action[0], queue_class[2:1]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // out_byte[7:0], copied_count[14:8], zero[15]
  input  logic        m_tlast,   // last
  input  logic [4:0]  m_tuser,   // kind[2:0], served_class[4:3]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          errors,
  output int          pending
);

  localparam int NumClasses = spfq_pkg::NumClasses;
  localparam int MaxBytes   = spfq_pkg::MaxFrameBytes;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] cls;
    logic [6:0] copied;
  } frame_result_t;

  // Mirror of the queue state
  logic [7:0]    frame_mem [spfq_pkg::TotalSlots*spfq_pkg::MaxFrameBytes];
  int            frame_len [spfq_pkg::TotalSlots];
  int            q_head [spfq_pkg::NumClasses];
  int            q_count [spfq_pkg::NumClasses];
  int            stage_count;
  int            stage_class;
  bit            stage_bad;
  int            out_limit;
  frame_result_t expected_results [$];

  function automatic int slots_of(int c);
    return (c == 0) ? spfq_pkg::KeepaliveSlots :
           (c == 1) ? spfq_pkg::EventSlots : spfq_pkg::DataSlots;
  endfunction

  function automatic int first_slot(int c);
    return (c == 0) ? 0 : (c == 1) ? spfq_pkg::KeepaliveSlots :
           spfq_pkg::KeepaliveSlots + spfq_pkg::EventSlots;
  endfunction

  function automatic int tail_of(int c);
    return first_slot(c) + (q_head[c] + q_count[c]) % slots_of(c);
  endfunction

  function automatic frame_result_t mk(logic [2:0] k, logic [7:0] d, logic l,
                                       logic [1:0] c, logic [6:0] n);
    frame_result_t r;
    r.kind = k; r.data = d; r.last = l; r.cls = c; r.copied = n;
    return r;
  endfunction

  // Stage one enqueued byte; commit or drop on the final byte
  task automatic predict_enqueue(int cls, logic [7:0] d, bit fin);
    int  c;
    bit  ok;
    if (stage_count == 0) stage_class = cls;
    c = stage_class;
    if (c >= NumClasses) stage_bad = 1;
    else if (stage_count < MaxBytes) begin
      if (q_count[c] >= slots_of(c)) stage_bad = 1;
      else frame_mem[tail_of(c)*MaxBytes + stage_count] = d;
    end else stage_bad = 1;
    if (stage_count <= MaxBytes) stage_count++;
    if (fin) begin
      ok = !stage_bad && c < NumClasses && stage_count <= MaxBytes &&
           q_count[c] < slots_of(c);
      if (ok) begin
        frame_len[tail_of(c)] = stage_count;
        q_count[c]++;
      end
      expected_results.push_back(mk(ok ? spfq_pkg::KIND_ACCEPTED : spfq_pkg::KIND_DROPPED,
                                    8'd0, 1'b1, (c < NumClasses) ? 2'(c) : 2'd0, 7'd0));
      stage_count = 0;
      stage_bad   = 0;
    end
  endtask

  // Serve the lowest non-empty class
  task automatic predict_drain();
    int c, slot, len, n;
    c = 0;
    while (c < NumClasses && q_count[c] == 0) c++;
    if (c >= NumClasses) begin
      expected_results.push_back(mk(spfq_pkg::KIND_NOTHING, 8'd0, 1'b1, 2'd0, 7'd0));
      return;
    end
    slot = first_slot(c) + q_head[c];
    len  = (frame_len[slot] > MaxBytes) ? MaxBytes : frame_len[slot];
    n    = (len < out_limit) ? len : out_limit;
    q_head[c] = (q_head[c] + 1) % slots_of(c);
    q_count[c]--;
    if (n == 0)
      expected_results.push_back(mk(spfq_pkg::KIND_EMPTY, 8'd0, 1'b1, 2'(c), 7'd0));
    for (int i = 0; i < n; i++)
      expected_results.push_back(mk(spfq_pkg::KIND_BYTE, frame_mem[slot*MaxBytes + i],
                                    i + 1 == n, 2'(c), 7'(n)));
  endtask

  // Compare result beats, then predict from input and register beats
  always @(posedge clk) begin
    frame_result_t got, want;
    if (rst) begin
      for (int c = 0; c < NumClasses; c++) begin
        q_head[c] = 0;
        q_count[c] = 0;
      end
      stage_count = 0;
      stage_class = 0;
      stage_bad   = 0;
      out_limit   = 64;
      expected_results.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = mk(m_tuser[2:0], m_tdata[7:0], m_tlast, m_tuser[4:3], m_tdata[14:8]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want || m_tdata[15] !== 1'b0) begin
            $display("%0t: result mismatch expected %p actual %p (pad %b)",
                     $time, want, got, m_tdata[15]);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0]) predict_drain();
        else predict_enqueue(int'(s_tuser[2:1]), s_tdata[7:0], s_tlast);
      end
      if (cfg_valid && cfg_ready) out_limit = int'(cfg_data);
      pending <= expected_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the strict-priority frame queues: clock, stimulus, verdict.
module tb;

  localparam int Watchdog = 20000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // data_byte[7:0]
  logic        s_tlast;   // last_byte
  logic [2:0]  s_tuser;   // action[0], queue_class[2:1]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // out_byte[7:0], copied_count[14:8], zero[15]
  logic        m_tlast;   // last
  logic [4:0]  m_tuser;   // kind[2:0], served_class[4:3]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;
  int          errors;
  int          pending;
  int          items;
  int          quiet_cycles;
  bit          steady;
  bit          hold_req;
  bit          hold;

  strict_priority_frame_queues_unit DUT (.*);

  spfq_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, none during the steady stretch, none at all while held
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      m_tready <= !hold && (steady || $urandom_range(99) >= 17);
    end
  end

  // Long receiver hold-off, counted here
  initial begin
    hold = 0;
    forever begin
      wait (hold_req);
      hold = 1;
      repeat (400) @(negedge clk);
      hold = 0;
      wait (!hold_req);
    end
  end

  // Watchdog on cycles with no beat anywhere
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= Watchdog) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one input beat and hold it until accepted
  task automatic put_item(bit drain, int cls, logic [7:0] d, bit fin);
    if (!steady) begin
      while ($urandom_range(99) < 17) begin
        s_tvalid <= 0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1;
    s_tuser  <= {2'(cls), drain};
    s_tdata  <= {8'd0, d};
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items++;
  endtask

  task automatic drain_one();
    put_item(1, $urandom_range(3), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Enqueue a frame, optionally with a drain in the middle of it
  task automatic frame(int cls, int len, bit mid_drain);
    int cut;
    cut = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      if (mid_drain && i == cut && i != 0) drain_one();
      put_item(0, (i == 0) ? cls : $urandom_range(3), 8'($urandom_range(255)),
               i == len - 1);
    end
  endtask

  // Let all results come out and the block settle
  task automatic settle();
    s_tvalid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_out_limit(int v);
    settle();
    cfg_valid <= 1;
    cfg_data  <= 7'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int n);
    int r;
    int target;
    target = items + n;
    while (items < target) begin
      r = $urandom_range(99);
      if (r < 30) drain_one();
      else if (r < 35) frame($urandom_range(3), $urandom_range(1, 3), 0);
      else if (r < 40) frame($urandom_range(2), $urandom_range(60, 68), 0);
      else frame($urandom_range(2), $urandom_range(1, 6), r < 50);
    end
  endtask

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tlast = 0; s_tuser = '0;
    cfg_valid = 0; cfg_data = '0;
    steady = 0; hold_req = 0; items = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty drain, byte extremes, bad class, full queue, long frame
    drain_one();
    frame(0, 1, 0);
    put_item(0, 2, 8'hFF, 0);
    put_item(0, 0, 8'h00, 1);
    put_item(0, 3, 8'hA5, 1);
    frame(0, 2, 0);
    frame(0, 1, 0);
    frame(1, 66, 0);
    frame(1, 64, 0);
    put_item(0, 2, 8'h5A, 0);
    drain_one();
    put_item(0, 1, 8'hC3, 1);
    repeat (6) drain_one();
    set_out_limit(0);
    frame(2, 3, 0);
    drain_one();
    drain_one();
    set_out_limit(1);
    frame(1, 4, 0);
    drain_one();

    // Random phases across register settings
    set_out_limit(64);
    steady = 1;
    random_phase(30);
    steady = 0;
    set_out_limit(5);
    random_phase(20);

    // Hold the receiver off while the sender keeps going
    hold_req = 1;
    for (int i = 0; i < 3; i++) begin
      frame($urandom_range(2), $urandom_range(3, 8), 0);
      drain_one();
    end
    hold_req = 0;
    settle();
    set_out_limit(63);
    random_phase(15);
    set_out_limit($urandom_range(64));
    random_phase(15);
    repeat (6) drain_one();

    settle();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/spfq_pkg.sv
sv/strict_priority_frame_queues_unit.sv
tb/spfq_checker.sv
tb/tb.sv
